// ===== src/selection_sort_values_assert.svh =====
// Assertion macros for the selection sorter.
// Used by the top level; no other dependencies.
`ifndef SELECTION_SORT_VALUES_ASSERT_SVH
`define SELECTION_SORT_VALUES_ASSERT_SVH
`ifndef ASSERT_OFF
`define SSV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSV_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SSV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/ssv_pkg.sv =====
// Shared types and constants for the selection sorter.
// No dependencies.
`default_nettype none
package ssv_pkg;

  localparam int VAL_W = 31;
  localparam int IDX_W = 5;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_last;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] sorted_value;
    logic [IDX_W-1:0] original_index;
    logic             is_last_result;
  } out_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] index;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // write the input item at the given address
    logic start;      // latch the sort direction for this batch
    logic rd_en;      // read the entry at the given address
    logic cap_best;   // take the read entry as the pass's first candidate
    logic cmp_en;     // compare the read entry against the best so far
    logic emit;       // hand the best entry out and swap it into place
    logic emit_last;  // the emitted entry closes the batch
  } cmd_t;

endpackage
`default_nettype wire

// ===== src/selection_sort_values.sv =====
// Selection sorter, top level: configuration register, controller and datapath.
// Depends on ssv_pkg, ssv_ctrl, ssv_datapath and selection_sort_values_assert.svh.
//
// The block collects a batch of 31-bit values, one per input transaction, and
// tags each with its arrival position. Values are taken while the block is idle.
// Once MAX_ITEMS entries are held, further values are dropped, but an item
// marked last still closes the batch. On the last item the batch is sorted in
// descending order when sort_descending is 1 (the reset value) and ascending
// otherwise, as the register stands when that item arrives. Every entry then
// leaves exactly once as an output transaction, carrying its value and its
// original index (the arrival position modulo 32); the final one carries
// is_last_result. Ties keep the earliest candidate of each selection pass.
// Each selection pass scans the remaining entries through the single read
// port of the entry memory, one entry per cycle; each sorted entry is
// released as soon as its pass ends and the output register can take it.
// The input is stalled from the last item until the final result has moved
// into the output register. There is no clearing pass after reset.
`default_nettype none
`include "selection_sort_values_assert.svh"
module selection_sort_values #(
  parameter int MAX_ITEMS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire ssv_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output ssv_pkg::out_t     out_data,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata
);

  // Address width for the entry memory, counter width to hold MAX_ITEMS itself.
  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic          sort_descending_r;
  ssv_pkg::cmd_t cmd;
  logic [AW-1:0] addr;
  logic          out_free;

  // The one configuration register; the datapath samples it on the last item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_descending_r <= 1'b1;
    end else if (cfg_we) begin
      sort_descending_r <= cfg_wdata;
    end
  end

  ssv_ctrl #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_last (in_data.is_last),
    .out_free   (out_free),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .addr       (addr)
  );

  ssv_datapath #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .addr            (addr),
    .in_data         (in_data),
    .sort_descending (sort_descending_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .out_free        (out_free)
  );

  // A result is only produced when the output register can take it.
  `SSV_ASSERT_SAME(a_emit_has_room, clk, rst_n, cmd.emit, (!out_valid || !out_stall))
  // Results are produced only while the input side is held off.
  `SSV_ASSERT_SAME(a_emit_while_busy, clk, rst_n, cmd.emit, in_stall)
  // A last item always starts a sort, which holds off the input.
  `SSV_ASSERT_NEXT(a_last_starts_sort, clk, rst_n,
    (in_valid && !in_stall && in_data.is_last), in_stall)

endmodule
`default_nettype wire

// ===== src/ssv_datapath.sv =====
// Datapath of the selection sorter: entry memory, best-candidate registers,
// output register. Depends on ssv_pkg.
`default_nettype none
module ssv_datapath #(
  parameter int MAX_ITEMS = 32,
  parameter int AW        = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ssv_pkg::cmd_t cmd,
  input  wire logic [AW-1:0] addr,
  input  wire ssv_pkg::in_t  in_data,
  input  wire logic          sort_descending,
  input  wire logic          out_stall,
  output logic               out_valid,
  output ssv_pkg::out_t      out_data,
  output logic               out_free
);

  localparam int IdxW = ssv_pkg::IDX_W;

  ssv_pkg::entry_t mem [MAX_ITEMS];
  ssv_pkg::entry_t rdata_r;
  logic [AW-1:0]   rd_addr_r;
  ssv_pkg::entry_t best_r, best_nxt;
  ssv_pkg::entry_t kval_r;
  logic [AW-1:0]   pick_r, pick_nxt;
  logic            dir_r;
  logic            better;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  ssv_pkg::entry_t wr_data;
  logic            out_valid_r;
  ssv_pkg::out_t   out_data_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (dir_r) begin
      better = rdata_r.value > best_r.value;
    end else begin
      better = rdata_r.value < best_r.value;
    end
  end

  // The entry that held position k moves to where the best one was found.
  assign wr_en   = cmd.load || cmd.emit;
  assign wr_addr = cmd.emit ? pick_r : addr;
  always_comb begin
    if (cmd.emit) begin
      wr_data = kval_r;
    end else begin
      wr_data.value = in_data.value;
      wr_data.index = IdxW'(addr);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r   <= mem[addr];
      rd_addr_r <= addr;
    end
  end

  always_comb begin
    best_nxt = best_r;
    pick_nxt = pick_r;
    if (cmd.cap_best || (cmd.cmp_en && better)) begin
      best_nxt = rdata_r;
      pick_nxt = rd_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    pick_r <= pick_nxt;
    if (cmd.cap_best) begin
      kval_r <= rdata_r;
    end
    if (cmd.emit) begin
      out_data_r.sorted_value   <= best_r.value;
      out_data_r.original_index <= best_r.index;
      out_data_r.is_last_result <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      dir_r       <= 1'b1;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.start) begin
        dir_r <= sort_descending;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== src/ssv_ctrl.sv =====
// Controller of the selection sorter: load counting, pass and scan sequencing.
// Depends on ssv_pkg.
`default_nettype none
module ssv_ctrl #(
  parameter int MAX_ITEMS = 32,
  parameter int AW        = 5,
  parameter int CW        = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_is_last,
  input  wire logic          out_free,
  output logic               in_stall,
  output ssv_pkg::cmd_t      cmd,
  output logic [AW-1:0]      addr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDK,
    S_CAPK,
    S_SCAN,
    S_EMIT
  } state_t;

  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ITEMS);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic          k_is_last;

  assign in_stall  = (state_r != S_IDLE);
  assign k_is_last = (CW'(k_r) == n_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    cmd       = '0;
    addr      = k_r;
    case (state_r)
      S_IDLE: begin
        addr = count_r[AW-1:0];
        if (in_valid) begin
          cmd.load = (count_r < MaxCnt);
          if (in_is_last) begin
            cmd.start = 1'b1;
            n_nxt     = count_r + CW'(cmd.load);
            count_nxt = '0;
            k_nxt     = '0;
            state_nxt = S_RDK;
          end else begin
            count_nxt = count_r + CW'(cmd.load);
          end
        end
      end
      S_RDK: begin
        cmd.rd_en = 1'b1;
        i_nxt     = CW'(k_r) + CW'(1);
        state_nxt = S_CAPK;
      end
      S_CAPK, S_SCAN: begin
        cmd.cap_best = (state_r == S_CAPK);
        cmd.cmp_en   = (state_r == S_SCAN);
        addr         = i_r[AW-1:0];
        if (i_r < n_r) begin
          cmd.rd_en = 1'b1;
          i_nxt     = i_r + CW'(1);
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = k_is_last;
          if (k_is_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_RDK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      n_r     <= '0;
      k_r     <= '0;
      i_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      i_r     <= i_nxt;
    end
  end

endmodule
`default_nettype wire
